// ===== rtl/core/bus_access_histogram_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bus access histogram
// Clocked, reset-qualified assertion shorthands used by the checker.
// ---------------------------------------------------------------------------
`ifndef BUS_ACCESS_HISTOGRAM_MACROS_SVH
`define BUS_ACCESS_HISTOGRAM_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BAH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define BAH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bah_pkg.sv =====
// ---------------------------------------------------------------------------
// Bus access histogram package
// Shared types, result codes and field layout for the histogram block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bah_pkg;

  localparam int ADDR_W  = 24;
  localparam int KEY_W   = 25;
  localparam int COUNT_W = 32;
  localparam int SLOT_W  = 5;
  localparam int ENTRY_W = KEY_W + COUNT_W;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

  // output tdata field positions
  localparam int OUT_SLOT_LSB  = 0;
  localparam int OUT_ADDR_LSB  = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_WR_BIT    = OUT_ADDR_LSB + ADDR_W;
  localparam int OUT_CNT_LSB   = OUT_WR_BIT + 1;
  localparam int OUT_VALID_BIT = OUT_CNT_LSB + COUNT_W;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_READ = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_READ,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic rd_idx;
    logic scan_step;
    logic set_readout;
    logic set_empty;
    logic set_hit;
    logic set_new;
    logic set_full;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic func;
    logic idx_hit;
    logic scan_done;
    logic chk_vld;
    logic chk_match;
    logic table_full;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/core/bah_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bah_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bah_ctrl.sv =====
// ---------------------------------------------------------------------------
// Bus access histogram controller
// Sequences accept, table scan or readout, result build and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bah_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bah_pkg::ctrl_sts_t sts,
  output bah_pkg::ctrl_cmd_t cmd
);

  import bah_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.func) begin
          if (sts.idx_hit) begin
            cmd.rd_idx = 1'b1;
            state_next = S_READ;
          end else begin
            cmd.set_empty = 1'b1;
            state_next    = S_FINISH;
          end
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // compare works on the registered read of the previous scan step; stop on first match
        if (sts.chk_match) begin
          cmd.set_hit = 1'b1;
          state_next  = S_FINISH;
        end else if (!sts.chk_vld && sts.scan_done) begin
          if (sts.table_full) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.set_new = 1'b1;
          end
          state_next = S_FINISH;
        end else if (!sts.scan_done) begin
          cmd.scan_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.set_readout = 1'b1;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bah_datapath.sv =====
// ---------------------------------------------------------------------------
// Bus access histogram datapath
// Entry RAM, fill count, scan pointer, key compare and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bah_datapath #(
  parameter int TABLE_SLOTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bah_pkg::ctrl_cmd_t            cmd,
  output bah_pkg::ctrl_sts_t            sts,
  input  logic                          in_func,
  input  logic [bah_pkg::ADDR_W-1:0]    in_address,
  input  logic                          in_is_write,
  input  logic [bah_pkg::SLOT_W-1:0]    in_slot_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bah_pkg::status_t              out_status,
  output logic [bah_pkg::SLOT_W-1:0]    out_slot,
  output logic [bah_pkg::ADDR_W-1:0]    out_address,
  output logic                          out_is_write,
  output logic [bah_pkg::COUNT_W-1:0]   out_count,
  output logic                          out_entry_valid
);

  import bah_pkg::*;

  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int IW = (CW > SLOT_W) ? CW : SLOT_W;

  // latched item
  logic              func;
  logic [KEY_W-1:0]  key;
  logic [SLOT_W-1:0] idx;

  // slots fill in order and counts never return to zero, so a slot is valid
  // exactly when its index is below the fill count
  logic [CW-1:0] fill;
  logic [CW-1:0] scan_ptr;
  logic          chk_vld;
  logic [AW-1:0] chk_ptr;

  // pending result
  status_t            res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic [KEY_W-1:0]   res_key;
  logic [COUNT_W-1:0] res_count;
  logic               res_valid;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [KEY_W-1:0]   rd_key;
  logic [COUNT_W-1:0] rd_count;
  logic [COUNT_W-1:0] cnt_inc;
  logic [IW-1:0]      idx_ext;
  logic [IW-1:0]      fill_ext;
  logic [IW-1:0]      chk_ext;

  assign rd_key   = ram_rdata[KEY_W-1:0];
  assign rd_count = ram_rdata[ENTRY_W-1:KEY_W];
  assign cnt_inc  = (&rd_count) ? rd_count : rd_count + COUNT_W'(1);
  assign idx_ext  = IW'(idx);
  assign fill_ext = IW'(fill);
  assign chk_ext  = IW'(chk_ptr);

  assign ram_raddr = cmd.rd_idx ? idx_ext[AW-1:0] : scan_ptr[AW-1:0];
  assign ram_we    = cmd.set_hit | cmd.set_new;
  assign ram_waddr = cmd.set_hit ? chk_ptr : fill[AW-1:0];
  assign ram_wdata = cmd.set_hit ? {cnt_inc, key} : {COUNT_W'(1), key};

  bah_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS),
    .AW   (AW)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    sts.func       = func;
    sts.idx_hit    = idx_ext < fill_ext;
    sts.scan_done  = scan_ptr == fill;
    sts.chk_vld    = chk_vld;
    sts.chk_match  = chk_vld && (rd_key == key);
    sts.table_full = fill == CW'(TABLE_SLOTS);
    sts.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func <= in_func;
      key  <= {in_is_write, in_address};
      idx  <= in_slot_index;
    end
    if (cmd.scan_step) begin
      chk_ptr <= scan_ptr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      scan_ptr <= '0;
      chk_vld  <= 1'b0;
    end else begin
      chk_vld <= cmd.scan_step;
      if (cmd.load_in) begin
        scan_ptr <= '0;
      end else if (cmd.scan_step) begin
        scan_ptr <= scan_ptr + CW'(1);
      end
      if (cmd.set_new) begin
        fill <= fill + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_readout) begin
      res_status <= ST_READ;
      res_slot   <= idx;
      res_key    <= rd_key;
      res_count  <= rd_count;
      res_valid  <= 1'b1;
    end else if (cmd.set_empty) begin
      res_status <= ST_READ;
      res_slot   <= idx;
      res_key    <= '0;
      res_count  <= '0;
      res_valid  <= 1'b0;
    end else if (cmd.set_hit) begin
      res_status <= ST_HIT;
      res_slot   <= chk_ext[SLOT_W-1:0];
      res_key    <= key;
      res_count  <= cnt_inc;
      res_valid  <= 1'b1;
    end else if (cmd.set_new) begin
      res_status <= ST_NEW;
      res_slot   <= fill_ext[SLOT_W-1:0];
      res_key    <= key;
      res_count  <= COUNT_W'(1);
      res_valid  <= 1'b1;
    end else if (cmd.set_full) begin
      res_status <= ST_FULL;
      res_slot   <= '0;
      res_key    <= key;
      res_count  <= '0;
      res_valid  <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status      <= res_status;
      out_slot        <= res_slot;
      out_address     <= res_key[ADDR_W-1:0];
      out_is_write    <= res_key[KEY_W-1];
      out_count       <= res_count;
      out_entry_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/bus_access_histogram.sv =====
// ---------------------------------------------------------------------------
// Bus access histogram
// Tallies bus accesses by address and direction in a table of counters.
// ---------------------------------------------------------------------------
// Each input beat is either a tally or a readout, and each gives exactly one
// output beat. A tally walks the filled slots (at most TABLE_SLOTS) in order
// through the single read port of the entry RAM, one slot a cycle. One item
// is worked on at a time; a new beat is taken once the previous result has
// moved into the output register, even while that result still waits on
// m_axis_tready. Counts saturate at all ones. Slots fill in order and never
// empty, so a fill count tracks which slots are valid and no clearing pass
// is needed after reset.
`timescale 1ns / 1ps

module bus_access_histogram #(
  parameter int TABLE_SLOTS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // access_address[23:0], access_is_write[24], slot_index[29:25], zero pad
  input  logic [bah_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // func[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // slot[4:0], entry_address[28:5], entry_is_write[29], entry_count[61:30],
  // entry_valid[62], zero pad
  output logic [bah_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // status[1:0]
  output logic [1:0]                          m_axis_tuser
);

  import bah_pkg::*;

  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;
  status_t            out_status;
  logic [SLOT_W-1:0]  out_slot;
  logic [ADDR_W-1:0]  out_address;
  logic               out_is_write;
  logic [COUNT_W-1:0] out_count;
  logic               out_entry_valid;

  bah_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  bah_datapath #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (s_axis_tuser),
    .in_address     (s_axis_tdata[ADDR_W-1:0]),
    .in_is_write    (s_axis_tdata[ADDR_W]),
    .in_slot_index  (s_axis_tdata[ADDR_W+SLOT_W:ADDR_W+1]),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_address    (out_address),
    .out_is_write   (out_is_write),
    .out_count      (out_count),
    .out_entry_valid(out_entry_valid)
  );

  assign m_axis_tdata = {1'b0, out_entry_valid, out_count, out_is_write,
                         out_address, out_slot};
  assign m_axis_tuser = out_status;

endmodule

// ===== rtl/core/bah_checker.sv =====
// ---------------------------------------------------------------------------
// Bus access histogram checker
// Port-level assertions on result consistency and stream behavior.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bus_access_histogram_macros.svh"

module bah_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bah_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser
);

  import bah_pkg::*;

  logic               in_beat;
  logic [COUNT_W-1:0] res_count;
  logic               res_valid;
  logic [SLOT_W-1:0]  res_slot;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign res_count = m_axis_tdata[OUT_CNT_LSB+COUNT_W-1:OUT_CNT_LSB];
  assign res_valid = m_axis_tdata[OUT_VALID_BIT];
  assign res_slot  = m_axis_tdata[OUT_SLOT_LSB+SLOT_W-1:OUT_SLOT_LSB];

  // a stalled result beat holds
  `BAH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

  // one item in flight: busy right after an accepted beat
  `BAH_ASSERT_NEXT(a_busy_after_accept, in_beat, !s_axis_tready, "input taken while an item is in flight")

  // a new entry always starts at one
  `BAH_ASSERT_SAME(a_new_count_one, m_axis_tvalid && (m_axis_tuser == ST_NEW), (res_count == COUNT_W'(1)) && res_valid, "new entry without count one")

  // a dropped access reports no slot and no count
  `BAH_ASSERT_SAME(a_full_empty, m_axis_tvalid && (m_axis_tuser == ST_FULL), (res_count == '0) && !res_valid && (res_slot == '0), "dropped access with slot or count")

  // valid mark agrees with a nonzero count
  `BAH_ASSERT_SAME(a_valid_count, m_axis_tvalid, res_valid == (res_count != '0), "valid mark disagrees with count")

endmodule

bind bus_access_histogram bah_checker u_bah_checker (.*);
